// ===== rtl/tmav_pkg.sv =====
`timescale 1ns / 1ps

package tmav_pkg;

    // Fixed field geometry
    localparam int SAMPLE_W = 16;
    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;

    // Axis codes
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Front-end sequencer states
    typedef enum logic [0:0] {
        F_IDLE,
        F_CALC
    } front_state_t;

    // Divider sequencer states
    typedef enum logic [1:0] {
        B_IDLE,
        B_LOAD,
        B_STEP,
        B_DONE
    } back_state_t;

endpackage

// ===== rtl/tmav_front.sv =====
`timescale 1ns / 1ps

module tmav_front
    import tmav_pkg::*;
#(
    parameter int WINDOW = 8,
    parameter int SUM_W  = 19,
    parameter int CNT_W  = 4,
    parameter int IDX_W  = 3
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SAMPLE_W-1:0]   sample_x,
    input  logic signed [SAMPLE_W-1:0]   sample_y,
    input  logic signed [SAMPLE_W-1:0]   sample_z,
    output logic                         push_valid,
    input  logic                         push_ready,
    output logic [3*SUM_W+CNT_W-1:0]     push_data
);

    localparam int ENTRY_W = AXES * SAMPLE_W;

    // Sample history, circular; the slot at wr_ptr holds the oldest sample once full
    logic [ENTRY_W-1:0] win_mem [WINDOW];

    front_state_t              state_reg, state_next;
    logic [IDX_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [SUM_W-1:0]   sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [SUM_W-1:0]   sum_x_next, sum_y_next, sum_z_next;
    logic [ENTRY_W-1:0]        samp_reg;
    logic [ENTRY_W-1:0]        old_reg;
    logic                      full;
    logic                      commit;
    logic signed [SUM_W-1:0]   old_x, old_y, old_z;

    assign full = (count_reg == CNT_W'(WINDOW));

    // Drop the oldest sample from the sums only once the window is full
    assign old_x = full ? SUM_W'($signed(old_reg[3*SAMPLE_W-1:2*SAMPLE_W])) : '0;
    assign old_y = full ? SUM_W'($signed(old_reg[2*SAMPLE_W-1:SAMPLE_W]))   : '0;
    assign old_z = full ? SUM_W'($signed(old_reg[SAMPLE_W-1:0]))            : '0;

    // Sequencer: accept, then update sums and hand off to the queue
    always_comb
    begin
        state_next  = state_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_z_next  = sum_z_reg;
        in_ready    = 1'b0;
        push_valid  = 1'b0;
        commit      = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = F_CALC;
                end
            end
            F_CALC:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    commit     = 1'b1;
                    state_next = F_IDLE;
                    sum_x_next = sum_x_reg
                               + SUM_W'($signed(samp_reg[3*SAMPLE_W-1:2*SAMPLE_W])) - old_x;
                    sum_y_next = sum_y_reg
                               + SUM_W'($signed(samp_reg[2*SAMPLE_W-1:SAMPLE_W])) - old_y;
                    sum_z_next = sum_z_reg
                               + SUM_W'($signed(samp_reg[SAMPLE_W-1:0])) - old_z;
                    if (!full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (wr_ptr_reg == IDX_W'(WINDOW - 1))
                    begin
                        wr_ptr_next = '0;
                    end
                    else
                    begin
                        wr_ptr_next = wr_ptr_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Queue entry carries the updated sums and the divisor
    always_comb
    begin
        push_data = {SUM_W'(sum_x_reg + SUM_W'($signed(samp_reg[3*SAMPLE_W-1:2*SAMPLE_W]))
                            - old_x),
                     SUM_W'(sum_y_reg + SUM_W'($signed(samp_reg[2*SAMPLE_W-1:SAMPLE_W]))
                            - old_y),
                     SUM_W'(sum_z_reg + SUM_W'($signed(samp_reg[SAMPLE_W-1:0])) - old_z),
                     full ? count_reg : CNT_W'(count_reg + CNT_W'(1))};
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_z_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            sum_z_reg  <= sum_z_next;
        end
    end

    // Capture the transaction and read the oldest slot
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            samp_reg <= {sample_x, sample_y, sample_z};
            old_reg  <= win_mem[wr_ptr_reg];
        end
    end

    // Store the new sample over the oldest slot
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            win_mem[wr_ptr_reg] <= samp_reg;
        end
    end

endmodule

// ===== rtl/tmav_queue.sv =====
`timescale 1ns / 1ps

module tmav_queue
    import tmav_pkg::*;
#(
    parameter int DATA_W = 61
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    // Two-entry queue between front and divider
    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        level_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (level_reg != 2'd2);
    assign pop_valid  = (level_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - 2'd1;
            end
        end
    end

    // Hold entry payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/tmav_divider.sv =====
`timescale 1ns / 1ps

module tmav_divider
    import tmav_pkg::*;
#(
    parameter int SUM_W = 19,
    parameter int CNT_W = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  logic [3*SUM_W+CNT_W-1:0]    pop_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  avg_x,
    output logic signed [SAMPLE_W-1:0]  avg_y,
    output logic signed [SAMPLE_W-1:0]  avg_z
);

    localparam int STEP_W = $clog2(SUM_W);

    back_state_t                state_reg, state_next;
    logic [3*SUM_W+CNT_W-1:0]   job_reg;
    logic [AXIS_W-1:0]          axis_reg, axis_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [SUM_W-1:0]           dq_reg, dq_next;
    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic                       neg_reg, neg_next;
    logic [SAMPLE_W-1:0]        res_reg [AXES];
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        avg_x_reg, avg_y_reg, avg_z_reg;
    logic                       load_job;
    logic                       store_res;
    logic                       load_out;
    logic [SUM_W-1:0]           sel_sum;
    logic [CNT_W-1:0]           divisor;
    logic [CNT_W:0]             rem_sh;
    logic                       ge;
    logic [SUM_W-1:0]           quot;
    logic [SAMPLE_W-1:0]        res_val;

    assign divisor = job_reg[CNT_W-1:0];

    // Pick the sum for the current axis
    always_comb
    begin
        case (axis_reg)
            AXIS_X:  sel_sum = job_reg[3*SUM_W+CNT_W-1:2*SUM_W+CNT_W];
            AXIS_Y:  sel_sum = job_reg[2*SUM_W+CNT_W-1:SUM_W+CNT_W];
            default: sel_sum = job_reg[SUM_W+CNT_W-1:CNT_W];
        endcase
    end

    // One restoring-division step on magnitudes
    assign rem_sh  = {rem_reg, dq_reg[SUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, divisor});
    assign quot    = {dq_reg[SUM_W-2:0], ge};
    assign res_val = neg_reg ? SAMPLE_W'(-quot) : SAMPLE_W'(quot);

    // Sequencer: load axis, iterate SUM_W steps, repeat per axis, then present
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        pop_ready  = 1'b0;
        load_job   = 1'b0;
        store_res  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    load_job   = 1'b1;
                    axis_next  = AXIS_X;
                    state_next = B_LOAD;
                end
            end
            B_LOAD:
            begin
                neg_next   = sel_sum[SUM_W-1];
                dq_next    = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : sel_sum;
                rem_next   = '0;
                step_next  = '0;
                state_next = B_STEP;
            end
            B_STEP:
            begin
                dq_next   = quot;
                rem_next  = ge ? CNT_W'(rem_sh - {1'b0, divisor}) : CNT_W'(rem_sh);
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    store_res = 1'b1;
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = B_DONE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + AXIS_W'(1);
                        state_next = B_LOAD;
                    end
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            axis_reg      <= AXIS_X;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        if (load_job)
        begin
            job_reg <= pop_data;
        end
        if (store_res)
        begin
            res_reg[axis_reg] <= res_val;
        end
        if (load_out)
        begin
            avg_x_reg <= res_reg[AXIS_X];
            avg_y_reg <= res_reg[AXIS_Y];
            avg_z_reg <= res_reg[AXIS_Z];
        end
    end

    assign out_valid = out_valid_reg;
    assign avg_x     = avg_x_reg;
    assign avg_y     = avg_y_reg;
    assign avg_z     = avg_z_reg;

endmodule

// ===== rtl/three_axis_moving_average_unit.sv =====
`timescale 1ns / 1ps

// Three-axis moving average with warm-up.
// Input channel: in_valid/in_ready with sample_x, sample_y, sample_z (signed 16 bit).
// Output channel: out_valid/out_ready with avg_x, avg_y, avg_z, the truncated mean of
// the last WINDOW samples per axis (of all samples so far while the window fills).
// The front accepts a transaction, reads the oldest sample from the history RAM and
// updates running sums; a two-entry queue passes sums and divisor on.
// The back divides each axis sum serially, one quotient bit per cycle, with
// SUM_W = 16 + clog2(WINDOW). It takes a new transaction only after it has
// presented the previous result; out_valid rises once the divider has gone
// through its load and step states for each axis and then its done state.
// Reset clears the fill count, sums and all handshake state; the history RAM is not
// cleared, since a slot is only read after it has been written.
// When the receiver stalls, the result holds in the output register, the divider
// finishes the next transaction and waits, the queue absorbs two more, and the front
// holds one further transaction with in_ready low until the queue frees a slot.
module three_axis_moving_average_unit
    import tmav_pkg::*;
#(
    parameter int WINDOW = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [SAMPLE_W-1:0]  sample_x,
    input  logic signed [SAMPLE_W-1:0]  sample_y,
    input  logic signed [SAMPLE_W-1:0]  sample_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  avg_x,
    output logic signed [SAMPLE_W-1:0]  avg_y,
    output logic signed [SAMPLE_W-1:0]  avg_z
);

    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int JOB_W  = 3 * SUM_W + CNT_W;

    logic             push_valid;
    logic             push_ready;
    logic [JOB_W-1:0] push_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [JOB_W-1:0] pop_data;

    // Accept samples and keep running sums
    tmav_front #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W),
        .CNT_W  (CNT_W),
        .IDX_W  (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_x   (sample_x),
        .sample_y   (sample_y),
        .sample_z   (sample_z),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple front from divider
    tmav_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Divide sums by the sample count
    tmav_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .avg_x     (avg_x),
        .avg_y     (avg_y),
        .avg_z     (avg_z)
    );

endmodule
